// File: src/lds_pkg.sv
// shared types, constants and helpers for the led driver frame serializer
// no dependencies; imported by every module of the block
package lds_pkg;

    localparam int NUM_CH     = 5;
    localparam int FRAME_LEN  = 17;
    localparam int POS_W      = 5;
    localparam int STEP_W     = 5;
    localparam int LEVEL_W    = 10;
    localparam int CUR_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int QUEUE_LEN  = 2;

    localparam logic [7:0] START_BIT    = 8'h80;
    localparam logic [7:0] ADDR_STANDBY = 8'h00;
    localparam logic [7:0] ADDR_RGB     = 8'h10;
    localparam logic [7:0] ADDR_WHITE   = 8'h20;
    localparam logic [7:0] ADDR_ALL     = 8'h30;
    localparam logic [7:0] ENABLE_ALL   = 8'h1F;
    localparam logic [7:0] CUR_KNEE     = 8'd64;
    localparam logic [7:0] CUR_OFFSET   = 8'd34;
    localparam logic [4:0] HALF_MASK    = 5'h1F;

    // steps inside one byte: 24 data steps, then the ack slot
    localparam logic [STEP_W-1:0] ACK_LOW   = 5'd24;
    localparam logic [STEP_W-1:0] ACK_DATA  = 5'd25;
    localparam logic [STEP_W-1:0] ACK_HIGH  = 5'd26;
    // steps of the stop sequence
    localparam logic [STEP_W-1:0] STOP_LOW  = 5'd0;
    localparam logic [STEP_W-1:0] STOP_HIGH = 5'd1;

    typedef struct packed {
        logic               req_type;
        logic [2:0]         chan_sel;
        logic [LEVEL_W-1:0] level;
    } lds_req_t;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic busy_res;
        logic frame_end;
    } lds_res_t;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_SKIP = 2'd1,
        OP_TICK = 2'd2
    } lds_op_t;

    typedef struct packed {
        lds_op_t            op;
        logic [2:0]         chan;
        logic [LEVEL_W-1:0] level;
    } lds_cmd_t;

    function automatic logic [CUR_W-1:0] remap_current(input logic [CUR_W-1:0] c);
        logic [CUR_W-1:0] r;
        if (c < CUR_KNEE)
        begin
            r = c;
        end
        else
        begin
            r = c + CUR_OFFSET;
        end
        return r;
    endfunction

endpackage

// File: src/lds_front.sv
// input stage: registers each request beat and classifies it into a command
// depends on lds_pkg
module lds_front
    import lds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lds_req_t req_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output lds_cmd_t cmd_data
);

    logic     valid_reg;
    logic     valid_next;
    lds_cmd_t cmd_reg;
    lds_cmd_t cmd_next;

    assign req_ready = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

    always_comb
    begin
        cmd_next.chan  = req_data.chan_sel;
        cmd_next.level = req_data.level;
        if (req_data.req_type)
        begin
            cmd_next.op = OP_TICK;
        end
        else if (req_data.chan_sel < 3'(NUM_CH))
        begin
            cmd_next.op = OP_SET;
        end
        else
        begin
            cmd_next.op = OP_SKIP;
        end
        if (req_valid && req_ready)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: src/lds_queue.sv
// two-entry command queue between the front and back parts
// depends on lds_pkg
module lds_queue
    import lds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  lds_cmd_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output lds_cmd_t pop_data
);

    lds_cmd_t   entry_reg [QUEUE_LEN];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = count_reg != 2'(QUEUE_LEN);
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/lds_back.sv
// execution part: channel levels, frame composer, two-wire transmitter, result register
// depends on lds_pkg
module lds_back
    import lds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  lds_cmd_t             cmd_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CUR_W-1:0]     cfg_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output lds_res_t             res_data
);

    logic [LEVEL_W-1:0] levels_reg [NUM_CH];
    logic [LEVEL_W-1:0] levels_next [NUM_CH];
    logic [CUR_W-1:0]   cur_reg [NUM_CH];
    logic [7:0]         frame_reg [FRAME_LEN];
    logic [7:0]         frame_new [FRAME_LEN];
    logic               pending_reg, pending_next;
    logic               sending_reg, sending_next;
    logic               clock_reg, clock_next;
    logic               data_reg, data_next;
    logic [POS_W-1:0]   byte_pos_reg, byte_pos_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               res_valid_reg, res_valid_next;
    lds_res_t           res_reg, res_next;

    logic               take;
    logic               compose;
    logic               busy;
    logic               last;
    logic               rgb;
    logic               white;
    logic [7:0]         byte_cur;
    logic [8:0]         step_prod;
    logic [2:0]         bit_num;
    logic [STEP_W-1:0]  phase;

    assign take      = cmd_valid && (!res_valid_reg || res_ready);
    assign cmd_ready = take;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // frame built from the levels as they stand when the frame starts
    always_comb
    begin
        rgb   = (levels_reg[0] != '0) || (levels_reg[1] != '0) || (levels_reg[2] != '0);
        white = (levels_reg[3] != '0) || (levels_reg[4] != '0);
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            frame_new[i] = 8'h00;
        end
        if (!rgb && !white)
        begin
            frame_new[0] = START_BIT | ADDR_STANDBY;
        end
        else
        begin
            if (!rgb)
            begin
                frame_new[0] = START_BIT | ADDR_WHITE;
            end
            else if (!white)
            begin
                frame_new[0] = START_BIT | ADDR_RGB;
            end
            else
            begin
                frame_new[0] = START_BIT | ADDR_ALL;
            end
            frame_new[1] = ENABLE_ALL;
            for (int i = 0; i < NUM_CH; i++)
            begin
                frame_new[2 + i] = (levels_reg[i] != '0) ? remap_current(cur_reg[i]) : 8'h00;
                frame_new[7 + 2 * i] = {3'b000, levels_reg[i][4:0] & HALF_MASK};
                frame_new[8 + 2 * i] = {3'b000, levels_reg[i][9:5] & HALF_MASK};
            end
        end
    end

    // step / 3 by reciprocal, valid for the 24 data steps of a byte
    always_comb
    begin
        step_prod = {4'b0000, step_reg} * 9'd11;
        bit_num   = step_prod[7:5];
        phase     = step_reg - STEP_W'({bit_num, 1'b0}) - STEP_W'(bit_num);
        byte_cur  = (byte_pos_reg < POS_W'(FRAME_LEN)) ? frame_reg[byte_pos_reg] : 8'h00;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            levels_next[i] = levels_reg[i];
        end
        pending_next   = pending_reg;
        sending_next   = sending_reg;
        clock_next     = clock_reg;
        data_next      = data_reg;
        byte_pos_next  = byte_pos_reg;
        step_next      = step_reg;
        busy           = 1'b0;
        last           = 1'b0;
        compose        = 1'b0;
        if (take)
        begin
            case (cmd_data.op)
                OP_SET:
                begin
                    if (levels_reg[cmd_data.chan] != cmd_data.level)
                    begin
                        pending_next = 1'b1;
                    end
                    levels_next[cmd_data.chan] = cmd_data.level;
                    busy = sending_reg;
                end
                OP_SKIP:
                begin
                    busy = sending_reg;
                end
                OP_TICK:
                begin
                    if (sending_reg)
                    begin
                        busy = 1'b1;
                        if (byte_pos_reg < POS_W'(FRAME_LEN))
                        begin
                            if (step_reg < ACK_LOW)
                            begin
                                if (phase == 5'd0)
                                begin
                                    clock_next = 1'b0;
                                end
                                else if (phase == 5'd1)
                                begin
                                    data_next = byte_cur[3'd7 - bit_num];
                                end
                                else
                                begin
                                    clock_next = 1'b1;
                                end
                            end
                            else if (step_reg == ACK_LOW)
                            begin
                                clock_next = 1'b0;
                            end
                            else if (step_reg == ACK_DATA)
                            begin
                                data_next = 1'b1;
                            end
                            else
                            begin
                                clock_next = 1'b1;
                            end
                            if (step_reg >= ACK_HIGH)
                            begin
                                step_next     = '0;
                                byte_pos_next = byte_pos_reg + 1'b1;
                            end
                            else
                            begin
                                step_next = step_reg + 1'b1;
                            end
                        end
                        else if (step_reg == STOP_LOW)
                        begin
                            clock_next = 1'b0;
                            step_next  = STOP_HIGH;
                        end
                        else if (step_reg == STOP_HIGH)
                        begin
                            clock_next = 1'b1;
                            step_next  = STOP_HIGH + 1'b1;
                        end
                        else
                        begin
                            data_next     = 1'b1;
                            sending_next  = 1'b0;
                            byte_pos_next = '0;
                            step_next     = '0;
                            last          = 1'b1;
                        end
                    end
                    else if (pending_reg)
                    begin
                        // start condition: data drops while clock idles
                        compose       = 1'b1;
                        pending_next  = 1'b0;
                        sending_next  = 1'b1;
                        byte_pos_next = '0;
                        step_next     = '0;
                        data_next     = 1'b0;
                        busy          = 1'b1;
                    end
                end
                default:
                begin
                    busy = sending_reg;
                end
            endcase
        end
        res_next.clock_line = clock_next;
        res_next.data_line  = data_next;
        res_next.busy_res   = busy;
        res_next.frame_end  = last;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                levels_reg[i] <= '0;
                cur_reg[i]    <= '0;
            end
            pending_reg   <= 1'b0;
            sending_reg   <= 1'b0;
            clock_reg     <= 1'b0;
            data_reg      <= 1'b0;
            byte_pos_reg  <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                levels_reg[i] <= levels_next[i];
            end
            if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_CH)))
            begin
                cur_reg[cfg_index] <= cfg_data;
            end
            pending_reg   <= pending_next;
            sending_reg   <= sending_next;
            clock_reg     <= clock_next;
            data_reg      <= data_next;
            byte_pos_reg  <= byte_pos_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
        if (compose)
        begin
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                frame_reg[i] <= frame_new[i];
            end
        end
    end

endmodule

// File: src/led_driver_frame_serializer_unit.sv
// a request goes through the front register and the queue before its result is registered
// throughput: one request per cycle; the back part retires one command a cycle
// unless results stall; each tick makes at most one pin write (a frame takes 463 ticks)
// a 2-entry command queue lets the front keep accepting while results stall
// reset (rst_n low, asynchronous): levels, currents, pending flag, pins and counters clear
// top level; depends on lds_pkg, lds_front, lds_queue, lds_back
module led_driver_frame_serializer_unit
    import lds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  lds_req_t             req_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output lds_res_t             res_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CUR_W-1:0]     cfg_data
);

    logic     f_valid, f_ready;
    lds_cmd_t f_cmd;
    logic     q_valid, q_ready;
    lds_cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    lds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_cmd)
    );

    lds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    lds_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_cmd),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

// File: src/lds_checker.sv
// port-level checks for the led driver frame serializer, bound to the top level
// depends on lds_pkg and led_driver_frame_serializer_unit
module lds_checker
    import lds_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input lds_req_t             req_data,
    input logic                 res_valid,
    input logic                 res_ready,
    input lds_res_t             res_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CUR_W-1:0]     cfg_data
);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // the last write of a frame belongs to the frame
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.frame_end |-> res_data.busy_res)
        else $error("frame end without busy");

    // stop sequence leaves both wires high
    a_end_pins: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.frame_end |-> res_data.clock_line && res_data.data_line)
        else $error("frame end with a wire low");

    // a request accepted into an empty pipe shows its result after the queue
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !res_valid |-> ##3 res_valid)
        else $error("result beat missing after request");

endmodule

bind led_driver_frame_serializer_unit lds_checker u_lds_checker (.*);
